@@ rtl/a85_pkg.sv @@
// ----------------------------------------------------------------------------
// a85_pkg: shared types and constants of the Ascii85 decoder
// Character codes, header phase encoding, queue entry layout and the
// padding factors used when a group ends early.
// ----------------------------------------------------------------------------
package a85_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] CHAR_LT    = 8'h3C;
    localparam logic [7:0] CHAR_TILDE = 8'h7E;
    localparam logic [7:0] CHAR_Z     = 8'h7A;
    localparam logic [7:0] CHAR_BANG  = 8'h21;
    localparam logic [7:0] CHAR_U     = 8'h75;

    localparam logic [2:0] GROUP_DIGITS = 3'd5;
    localparam logic [2:0] BYTES_FULL   = 3'd4;

    typedef enum logic [3:0] {
        PH_OPEN   = 4'b0001,
        PH_TILDE  = 4'b0010,
        PH_BODY   = 4'b0100,
        PH_IGNORE = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [31:0] value;
        logic [2:0]  nbytes;
    } q_entry_t;

    // Padding with 'u' digits turns a partial group g into (g + 1) * 85^k - 1.
    function automatic logic [31:0] pad_mult(input logic [2:0] cnt);
        logic [31:0] m;
        case (cnt)
            3'd2:    m = 32'd614125;
            3'd3:    m = 32'd7225;
            3'd4:    m = 32'd85;
            default: m = 32'd1;
        endcase
        return m;
    endfunction

endpackage

@@ rtl/a85_front.sv @@
// ----------------------------------------------------------------------------
// a85_front: character intake and group accumulation
// Tracks the header, gathers base-85 digits and pushes one queue entry for
// every character that produces bytes.
// ----------------------------------------------------------------------------
module a85_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [7:0]         in_char,
    input  logic               start_of_string,
    output logic               push,
    output a85_pkg::q_entry_t  push_entry
);

    a85_pkg::phase_t phase_reg, phase_next;
    logic [2:0]      cnt_reg, cnt_next;
    logic [31:0]     group_reg, group_next;

    a85_pkg::phase_t eff_phase;
    logic [2:0]      eff_cnt;
    logic [31:0]     eff_group;
    logic [7:0]      digit;
    logic [31:0]     acc_value;
    logic [31:0]     pad_value;

    always_comb
    begin
        eff_phase = start_of_string ? a85_pkg::PH_OPEN : phase_reg;
        eff_cnt   = start_of_string ? 3'd0 : cnt_reg;
        eff_group = start_of_string ? 32'd0 : group_reg;
        digit     = in_char - a85_pkg::CHAR_BANG;
        acc_value = 32'(eff_group * 32'd85) + {24'd0, digit};
        pad_value = 32'((eff_group + 32'd1) * a85_pkg::pad_mult(eff_cnt)) - 32'd1;
    end

    always_comb
    begin
        phase_next = eff_phase;
        cnt_next   = eff_cnt;
        group_next = eff_group;
        push       = 1'b0;
        push_entry = '{value: acc_value, nbytes: a85_pkg::BYTES_FULL};
        case (eff_phase)
            a85_pkg::PH_OPEN:
            begin
                phase_next = (in_char == a85_pkg::CHAR_LT) ? a85_pkg::PH_TILDE
                                                           : a85_pkg::PH_IGNORE;
            end
            a85_pkg::PH_TILDE:
            begin
                phase_next = (in_char == a85_pkg::CHAR_TILDE) ? a85_pkg::PH_BODY
                                                              : a85_pkg::PH_IGNORE;
            end
            a85_pkg::PH_BODY:
            begin
                if (in_char inside {[a85_pkg::CHAR_BANG:a85_pkg::CHAR_U]})
                begin
                    if (eff_cnt == a85_pkg::GROUP_DIGITS - 3'd1)
                    begin
                        push       = 1'b1;
                        cnt_next   = 3'd0;
                        group_next = 32'd0;
                    end
                    else
                    begin
                        cnt_next   = eff_cnt + 3'd1;
                        group_next = acc_value;
                    end
                end
                else if (in_char == a85_pkg::CHAR_Z)
                begin
                    if (eff_cnt == 3'd0)
                    begin
                        push       = 1'b1;
                        push_entry = '{value: 32'd0, nbytes: a85_pkg::BYTES_FULL};
                    end
                end
                else if (in_char == a85_pkg::CHAR_TILDE)
                begin
                    if (eff_cnt >= 3'd2)
                    begin
                        push       = 1'b1;
                        push_entry = '{value: pad_value, nbytes: eff_cnt - 3'd1};
                    end
                    cnt_next   = 3'd0;
                    group_next = 32'd0;
                    phase_next = a85_pkg::PH_IGNORE;
                end
            end
            default:
            begin
                phase_next = a85_pkg::PH_IGNORE;
            end
        endcase
        push = push && accept;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= a85_pkg::PH_OPEN;
            cnt_reg   <= 3'd0;
            group_reg <= 32'd0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            group_reg <= group_next;
        end
    end

endmodule

@@ rtl/a85_queue.sv @@
// ----------------------------------------------------------------------------
// a85_queue: short queue of pending byte groups
// Decouples character intake from byte output; holds decoded words with
// their byte counts.
// ----------------------------------------------------------------------------
module a85_queue
#(
    parameter int DEPTH = a85_pkg::QUEUE_DEPTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  a85_pkg::q_entry_t  push_entry,
    input  logic               pop,
    output logic               full,
    output logic               head_valid,
    output a85_pkg::q_entry_t  head_entry
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    a85_pkg::q_entry_t mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    always_comb
    begin
        full        = (count_reg == FULL_CNT);
        head_valid  = (count_reg != '0);
        head_entry  = mem[rd_ptr_reg];
        wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        count_next  = count_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
            count_reg <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("queue read while empty");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("queue count out of range");
    a_head_nbytes: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> (head_entry.nbytes >= 3'd1 && head_entry.nbytes <= 3'd4))
        else $error("queue head holds an invalid byte count");
`endif

endmodule

@@ rtl/a85_back.sv @@
// ----------------------------------------------------------------------------
// a85_back: byte output stage
// Splits the queued word into bytes, most significant first, and drives
// the output register.
// ----------------------------------------------------------------------------
module a85_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  a85_pkg::q_entry_t  head_entry,
    output logic               pop,
    input  logic               out_stall,
    output logic               out_valid,
    output logic [7:0]         out_byte,
    output logic               last_of_run
);

    logic [1:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       last_reg, last_next;
    logic       load;

    always_comb
    begin
        load      = head_valid && (!valid_reg || !out_stall);
        byte_next = head_entry.value[31 - 8 * idx_reg -: 8];
        last_next = ({1'b0, idx_reg} == head_entry.nbytes - 3'd1);
        pop       = load && last_next;
        idx_next  = pop ? 2'd0 : idx_reg + 2'd1;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (load)
            begin
                idx_reg <= idx_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= byte_next;
            last_reg <= last_next;
        end
    end

    assign out_valid   = valid_reg;
    assign out_byte    = byte_reg;
    assign last_of_run = last_reg;

endmodule

@@ rtl/ascii85_decoder_core.sv @@
// ----------------------------------------------------------------------------
// ascii85_decoder_core: streaming Ascii85 decoder
// Accepts one character per transaction and returns the decoded bytes.
//
//   Channel  Direction  Payload                      Handshake
//   in       input      in_char, start_of_string     in_valid / in_stall
//   out      output     out_byte, last_of_run        out_valid / out_stall
//
// A character is taken every cycle while the queue has room.
// The output register gives one byte per cycle while out_stall is low, so a
// full group takes four output bytes; the queue depth sets how far intake can run ahead.
// A character is written into the queue at the edge that accepts it, and its
// first byte then passes from the queue head into the output register.
// Reset clears the header phase, the pending group and the queue.
// ----------------------------------------------------------------------------
module ascii85_decoder_core
#(
    parameter int QUEUE_DEPTH = a85_pkg::QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_char,
    input  logic       start_of_string,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       last_of_run
);

    logic              accept;
    logic              push;
    logic              pop;
    logic              full;
    logic              head_valid;
    a85_pkg::q_entry_t push_entry;
    a85_pkg::q_entry_t head_entry;

    assign in_stall = full;
    assign accept   = in_valid && !full;

    a85_front u_front
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .in_char         (in_char),
        .start_of_string (start_of_string),
        .push            (push),
        .push_entry      (push_entry)
    );

    a85_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    a85_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_entry  (head_entry),
        .pop         (pop),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .out_byte    (out_byte),
        .last_of_run (last_of_run)
    );

endmodule
